>>> rtl/pfiu_pkg.sv
// pfiu_pkg: shared types, sizes and helpers of the packed face index unpacker
// used by the channel interfaces and the top level
`default_nettype none

package pfiu_pkg;

    // store depths
    localparam int MAX_SEGMENTS = 64;
    localparam int PACKED_BYTES = 4096;
    localparam int INDEX_WORDS  = 4096;

    localparam int SEG_AW = $clog2(MAX_SEGMENTS);
    localparam int PB_AW  = $clog2(PACKED_BYTES);
    localparam int IW_AW  = $clog2(INDEX_WORDS);

    // field widths
    localparam int TC_W     = 7;
    localparam int FACE_W   = 14;
    localparam int BITPOS_W = 14;
    localparam int SUM_W    = 17;

    typedef enum logic [1:0] {
        CMD_LOAD_SEG  = 2'd0,
        CMD_LOAD_BYTE = 2'd1,
        CMD_LOAD_WORD = 2'd2,
        CMD_QUERY     = 2'd3
    } pfiu_cmd_t;

    localparam logic [1:0] STATUS_FOUND       = 2'd0;
    localparam logic [1:0] STATUS_NO_SEGMENT  = 2'd1;
    localparam logic [1:0] STATUS_BAD_ADDRESS = 2'd2;

    typedef struct packed {
        pfiu_cmd_t   command;
        logic [11:0] address;
        logic [15:0] data;
        logic [7:0]  entry_count;
        logic [7:0]  entry_width_code;
        logic [15:0] entry_face_base;
        logic [11:0] entry_byte_offset;
        logic [13:0] face_number;
    } pfiu_req_t;

    typedef struct packed {
        logic [15:0] vertex_a;
        logic [15:0] vertex_b;
        logic [15:0] vertex_c;
        logic [1:0]  status;
    } pfiu_rsp_t;

    typedef struct packed {
        logic [7:0]  count;
        logic [7:0]  width_code;
        logic [15:0] face_base;
        logic [11:0] byte_offset;
    } seg_desc_t;

    localparam int SEG_W = $bits(seg_desc_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_SEG,
        ST_SETUP,
        ST_BYTE0,
        ST_BYTE0_WAIT,
        ST_BYTE1_WAIT,
        ST_WORD,
        ST_WORD_WAIT,
        ST_FINISH
    } pfiu_state_t;

    // number of significant bits of an 8-bit value
    function automatic logic [3:0] bit_length8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (v[i])
            begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pfiu_chan_if.sv
// pfiu_chan_if: valid/ready channels for requests and results
// depends on pfiu_pkg for the payload structs
`default_nettype none

interface pfiu_req_if import pfiu_pkg::*; ();
    logic      valid;
    logic      ready;
    pfiu_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pfiu_rsp_if import pfiu_pkg::*; ();
    logic      valid;
    logic      ready;
    pfiu_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/pfiu_ram.sv
// pfiu_ram: generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module pfiu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/packed_face_index_unpacker.sv
// packed_face_index_unpacker: segment walk and packed index extraction
// depends on pfiu_pkg, pfiu_chan_if and pfiu_ram
//
// usage
//   req channel carries commands: load descriptor, load packed byte, load
//   index word, query face. rsp channel returns one result per query with
//   three vertex indices and a status; loads give no result. the user must
//   write table_count by cfg_we/cfg_wdata while the block is idle, unchecked.
// timing
//   a load is taken while idle and req.ready stays high.
//   a query holds req.ready low while a small sequencer runs it over the
//   single read port of each store: ST_WALK and ST_SEG per descriptor
//   walked, ST_SETUP, then per extracted value ST_BYTE0, ST_BYTE0_WAIT,
//   ST_BYTE1_WAIT when it spans two bytes, ST_WORD and ST_WORD_WAIT, and
//   ST_FINISH to hand the result over. the next request is taken after
//   that, so queries do not overlap; loads come every cycle while idle.
// reset
//   clears the sequencer, the result valid flag and table_count; the stores
//   are not cleared and must be loaded before use.
// stall
//   a finished result waits in the output register; the next request is
//   taken meanwhile, and a later query holds in its last state until the
//   output register frees up.
`default_nettype none

module packed_face_index_unpacker import pfiu_pkg::*; (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [TC_W-1:0] cfg_wdata,
    pfiu_req_if.sink             req,
    pfiu_rsp_if.source           rsp
);

    pfiu_state_t state_reg, state_next;
    logic [TC_W-1:0]     table_count_reg;
    logic [FACE_W-1:0]   cur_reg, cur_next;
    logic [TC_W-1:0]     seg_idx_reg, seg_idx_next;
    seg_desc_t           desc_reg, desc_next;
    logic [3:0]          width_reg, width_next;
    logic [BITPOS_W-1:0] bitpos_reg, bitpos_next;
    logic [1:0]          k_reg, k_next;
    logic [7:0]          lo_reg, lo_next;
    logic [7:0]          hi_reg, hi_next;
    logic [SUM_W-1:0]    baddr_reg, baddr_next;
    logic [1:0]          status_reg, status_next;
    logic [15:0]         vert_reg [3];
    logic [15:0]         vert_next [3];
    pfiu_rsp_t           out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    // store ports
    logic              seg_we, seg_re;
    logic [SEG_AW-1:0] seg_waddr, seg_raddr;
    logic [SEG_W-1:0]  seg_wdata, seg_rdata;
    logic              byte_we, byte_re;
    logic [PB_AW-1:0]  byte_waddr, byte_raddr;
    logic [7:0]        byte_rdata;
    logic              word_we, word_re;
    logic [IW_AW-1:0]  word_waddr, word_raddr;
    logic [15:0]       word_rdata;

    logic              accept;
    seg_desc_t         seg_desc_rd;
    seg_desc_t         seg_desc_wr;
    logic [9:0]        pos0;
    logic [SUM_W-1:0]  byte_sum;
    logic [SUM_W-1:0]  baddr_inc;
    logic [3:0]        bit_end;
    logic [15:0]       bits16;
    logic [15:0]       shifted;
    logic [8:0]        mask;
    logic [7:0]        value;
    logic [SUM_W-1:0]  word_sum;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.payload = out_reg;

    // load side
    always_comb
    begin
        seg_desc_wr.count       = req.payload.entry_count;
        seg_desc_wr.width_code  = req.payload.entry_width_code;
        seg_desc_wr.face_base   = req.payload.entry_face_base;
        seg_desc_wr.byte_offset = req.payload.entry_byte_offset;
    end

    assign seg_we = accept && (req.payload.command == CMD_LOAD_SEG)
                 && (32'(req.payload.address) < MAX_SEGMENTS);
    assign seg_waddr  = SEG_AW'(req.payload.address);
    assign seg_wdata  = seg_desc_wr;
    assign byte_we = accept && (req.payload.command == CMD_LOAD_BYTE)
                  && (32'(req.payload.address) < PACKED_BYTES);
    assign byte_waddr = PB_AW'(req.payload.address);
    assign word_we = accept && (req.payload.command == CMD_LOAD_WORD)
                  && (32'(req.payload.address) < INDEX_WORDS);
    assign word_waddr = IW_AW'(req.payload.address);

    pfiu_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
        .clk   (clk),
        .we    (seg_we),
        .waddr (seg_waddr),
        .wdata (seg_wdata),
        .re    (seg_re),
        .raddr (seg_raddr),
        .rdata (seg_rdata)
    );

    pfiu_ram #(.WIDTH(8), .DEPTH(PACKED_BYTES)) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (req.payload.data[7:0]),
        .re    (byte_re),
        .raddr (byte_raddr),
        .rdata (byte_rdata)
    );

    pfiu_ram #(.WIDTH(16), .DEPTH(INDEX_WORDS)) u_word_ram (
        .clk   (clk),
        .we    (word_we),
        .waddr (word_waddr),
        .wdata (req.payload.data),
        .re    (word_re),
        .raddr (word_raddr),
        .rdata (word_rdata)
    );

    // datapath terms
    assign seg_desc_rd = seg_desc_t'(seg_rdata);
    assign pos0      = {2'b00, cur_reg[7:0]} + {1'b0, cur_reg[7:0], 1'b0};
    assign byte_sum  = SUM_W'(desc_reg.byte_offset) + SUM_W'(bitpos_reg[BITPOS_W-1:3]);
    assign baddr_inc = baddr_reg + SUM_W'(1);
    assign bit_end   = {1'b0, bitpos_reg[2:0]} + width_reg;
    assign bits16    = {hi_reg, lo_reg};
    assign shifted   = bits16 >> bitpos_reg[2:0];
    assign mask      = (9'd1 << width_reg) - 9'd1;
    // bits above the value are masked, so a stale high byte does no harm
    assign value     = shifted[7:0] & mask[7:0];
    assign word_sum  = SUM_W'(value) + SUM_W'(desc_reg.face_base);

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        seg_idx_next   = seg_idx_reg;
        desc_next      = desc_reg;
        width_next     = width_reg;
        bitpos_next    = bitpos_reg;
        k_next         = k_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        baddr_next     = baddr_reg;
        status_next    = status_reg;
        vert_next      = vert_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        seg_re         = 1'b0;
        seg_raddr      = SEG_AW'(seg_idx_reg);
        byte_re        = 1'b0;
        byte_raddr     = byte_sum[PB_AW-1:0];
        word_re        = 1'b0;
        word_raddr     = word_sum[IW_AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.payload.command == CMD_QUERY))
                begin
                    cur_next     = req.payload.face_number;
                    seg_idx_next = '0;
                    state_next   = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (seg_idx_reg >= table_count_reg)
                begin
                    status_next = STATUS_NO_SEGMENT;
                    state_next  = ST_FINISH;
                end
                else if (32'(seg_idx_reg) >= MAX_SEGMENTS)
                begin
                    status_next = STATUS_BAD_ADDRESS;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    seg_re     = 1'b1;
                    state_next = ST_SEG;
                end
            end
            ST_SEG:
            begin
                if (cur_reg < FACE_W'(seg_desc_rd.count))
                begin
                    desc_next  = seg_desc_rd;
                    width_next = bit_length8(seg_desc_rd.width_code - 8'd1);
                    state_next = ST_SETUP;
                end
                else
                begin
                    cur_next     = cur_reg - FACE_W'(seg_desc_rd.count);
                    seg_idx_next = seg_idx_reg + TC_W'(1);
                    state_next   = ST_WALK;
                end
            end
            ST_SETUP:
            begin
                // first value sits at position 3*f
                bitpos_next = BITPOS_W'(pos0) * BITPOS_W'(width_reg);
                k_next      = 2'd0;
                state_next  = ST_BYTE0;
            end
            ST_BYTE0:
            begin
                baddr_next = byte_sum;
                if (32'(byte_sum) >= PACKED_BYTES)
                begin
                    status_next = STATUS_BAD_ADDRESS;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    byte_re    = 1'b1;
                    state_next = ST_BYTE0_WAIT;
                end
            end
            ST_BYTE0_WAIT:
            begin
                lo_next    = byte_rdata;
                byte_raddr = baddr_inc[PB_AW-1:0];
                if (bit_end > 4'd8)
                begin
                    // value spans into the next byte
                    if (32'(baddr_inc) >= PACKED_BYTES)
                    begin
                        status_next = STATUS_BAD_ADDRESS;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        byte_re    = 1'b1;
                        state_next = ST_BYTE1_WAIT;
                    end
                end
                else
                begin
                    state_next = ST_WORD;
                end
            end
            ST_BYTE1_WAIT:
            begin
                hi_next    = byte_rdata;
                state_next = ST_WORD;
            end
            ST_WORD:
            begin
                if (32'(word_sum) >= INDEX_WORDS)
                begin
                    status_next = STATUS_BAD_ADDRESS;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    word_re    = 1'b1;
                    state_next = ST_WORD_WAIT;
                end
            end
            ST_WORD_WAIT:
            begin
                vert_next[k_reg] = word_rdata;
                if (k_reg == 2'd2)
                begin
                    status_next = STATUS_FOUND;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    k_next      = k_reg + 2'd1;
                    bitpos_next = bitpos_reg + BITPOS_W'(width_reg);
                    state_next  = ST_BYTE0;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_next.status = status_reg;
                    if (status_reg == STATUS_FOUND)
                    begin
                        out_next.vertex_a = vert_reg[0];
                        out_next.vertex_b = vert_reg[1];
                        out_next.vertex_c = vert_reg[2];
                    end
                    else
                    begin
                        out_next.vertex_a = '0;
                        out_next.vertex_b = '0;
                        out_next.vertex_c = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            table_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                table_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        seg_idx_reg <= seg_idx_next;
        desc_reg    <= desc_next;
        width_reg   <= width_next;
        bitpos_reg  <= bitpos_next;
        k_reg       <= k_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        baddr_reg   <= baddr_next;
        status_reg  <= status_next;
        vert_reg    <= vert_next;
        out_reg     <= out_next;
    end

    // checks
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.payload.status != STATUS_FOUND)) |->
            (rsp.payload.vertex_a == 16'd0 && rsp.payload.vertex_b == 16'd0
             && rsp.payload.vertex_c == 16'd0))
        else $error("failed query carries nonzero vertices");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");

    a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEG) |->
            (seg_idx_reg < table_count_reg && 32'(seg_idx_reg) < MAX_SEGMENTS))
        else $error("descriptor read beyond the table");

    a_value_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BYTE0) |-> (k_reg != 2'd3))
        else $error("more than three values extracted");

endmodule

`default_nettype wire
